>>> hdl/dxt_single_color_endpoint_search_assert.svh
// assertion macros shared by the endpoint search modules
`ifndef DXT_SINGLE_COLOR_ENDPOINT_SEARCH_ASSERT_SVH
`define DXT_SINGLE_COLOR_ENDPOINT_SEARCH_ASSERT_SVH

// same-cycle implication, checked outside reset
`define DXTSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("dxtsc same-cycle check failed");

// next-cycle implication, checked outside reset
`define DXTSC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("dxtsc next-cycle check failed");

`endif

>>> hdl/dxtsc_pkg.sv
package dxtsc_pkg;

	localparam int unsigned TARGET_W = 8;
	localparam int unsigned CODE_W   = 6;
	localparam int unsigned CFG_W    = 3;
	localparam int unsigned ERR_W    = 15;
	localparam int unsigned SUM_W    = 10;
	localparam int unsigned PROD_W   = 20;

	localparam logic [ERR_W-1:0] ERR_START = ERR_W'(256 * 100);
	localparam logic [6:0] ERR_INTERP_WEIGHT = 7'd100;
	localparam logic [1:0] ERR_SPREAD_WEIGHT = 2'd3;

	// floor(x/3) == (x*683)>>11 for every x up to 765
	localparam logic [SUM_W-1:0] RECIP_3     = SUM_W'(683);
	localparam int unsigned      RECIP_SHIFT = 11;

	localparam logic [CFG_W-1:0] ENDPOINT_BITS_RESET = CFG_W'(5);
	localparam logic [CFG_W-1:0] ENDPOINT_BITS_WIDE  = CFG_W'(6);

	localparam logic [CODE_W-1:0] CODE_MAX_NARROW = CODE_W'(31);
	localparam logic [CODE_W-1:0] CODE_MAX_WIDE   = CODE_W'(63);

	// controller to datapath
	typedef struct packed {
		logic start;
		logic run;
		logic load_out;
	} dxtsc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last_pair;
		logic pipe_busy;
		logic out_free;
	} dxtsc_sts_t;

	// bit-replicated expansion of a 5-bit or 6-bit code to 8 bits
	function automatic logic [TARGET_W-1:0] expand_code(input logic [CODE_W-1:0] c,
			input logic wide);
		logic [TARGET_W-1:0] e;
		if (wide) begin
			e = {c, c[5:4]};
		end else begin
			e = {c[4:0], c[4:2]};
		end
		return e;
	endfunction

endpackage

>>> hdl/dxtsc_ctrl.sv
`include "dxt_single_color_endpoint_search_assert.svh"

module dxtsc_ctrl
	import dxtsc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dxtsc_sts_t sts,
	output dxtsc_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	state_t state_q;

	// command decode
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = in_valid;
			end
			ST_SCAN: begin
				cmd.run = 1'b1;
			end
			ST_DRAIN: begin
				cmd.load_out = !sts.pipe_busy && sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (sts.last_pair) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (!sts.pipe_busy && sts.out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// a started transaction always goes into the scan
	`DXTSC_ASSERT_NXT(a_start_scan, clk, arst_n, cmd.start, state_q == ST_SCAN)

endmodule

>>> hdl/dxtsc_dpath.sv
`include "dxt_single_color_endpoint_search_assert.svh"

module dxtsc_dpath
	import dxtsc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  dxtsc_cmd_t          cmd,
	output dxtsc_sts_t          sts,
	input  logic                cfg_write_en,
	input  logic [CFG_W-1:0]    cfg_write_data,
	input  logic [TARGET_W-1:0] target_value,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [CODE_W-1:0]   high_endpoint,
	output logic [CODE_W-1:0]   low_endpoint
);

	logic [CFG_W-1:0]    endpoint_bits_q;
	logic [TARGET_W-1:0] target_q;
	logic                wide_q;
	logic [CODE_W-1:0]   lo_q, hi_q;
	logic [CODE_W-1:0]   code_max;

	logic                valid_s1, valid_s2;
	logic [TARGET_W-1:0] interp_s1;
	logic [CODE_W-1:0]   spread_s1;
	logic [CODE_W-1:0]   lo_s1, hi_s1, lo_s2, hi_s2;
	logic [ERR_W-1:0]    err_s2;

	logic [ERR_W-1:0]    best_err_q;
	logic [CODE_W-1:0]   best_lo_q, best_hi_q;
	logic                out_valid_q;
	logic [CODE_W-1:0]   out_hi_q, out_lo_q;

	logic [TARGET_W-1:0] e_hi, e_lo;
	logic [SUM_W-1:0]    sum;
	logic [PROD_W-1:0]   prod;
	logic [CODE_W-1:0]   spread;
	logic [TARGET_W-1:0] interp_diff;
	logic [ERR_W-1:0]    err;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			endpoint_bits_q <= ENDPOINT_BITS_RESET;
		end else if (cfg_write_en) begin
			endpoint_bits_q <= cfg_write_data;
		end
	end

	// pair counters, low code outer and high code inner
	assign code_max = wide_q ? CODE_MAX_WIDE : CODE_MAX_NARROW;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q <= '0;
			hi_q <= '0;
		end else if (cmd.start) begin
			lo_q <= '0;
			hi_q <= '0;
		end else if (cmd.run) begin
			if (hi_q == code_max) begin
				hi_q <= '0;
				lo_q <= lo_q + CODE_W'(1);
			end else begin
				hi_q <= hi_q + CODE_W'(1);
			end
		end
	end

	// target and code width captured with the transaction
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			target_q <= target_value;
			wide_q   <= (endpoint_bits_q >= ENDPOINT_BITS_WIDE);
		end
	end

	// stage 1: expand, interpolate, spread
	always_comb begin
		e_hi   = expand_code(hi_q, wide_q);
		e_lo   = expand_code(lo_q, wide_q);
		sum    = {1'b0, e_hi, 1'b0} + {2'b00, e_lo};
		prod   = PROD_W'(sum) * PROD_W'(RECIP_3);
		spread = (hi_q > lo_q) ? (hi_q - lo_q) : (lo_q - hi_q);
	end

	always_ff @(posedge clk) begin
		interp_s1 <= prod[RECIP_SHIFT +: TARGET_W];
		spread_s1 <= spread;
		lo_s1     <= lo_q;
		hi_s1     <= hi_q;
	end

	// stage 2: weighted error
	always_comb begin
		interp_diff = (interp_s1 > target_q) ? (interp_s1 - target_q) : (target_q - interp_s1);
		err  = ERR_W'(interp_diff) * ERR_W'(ERR_INTERP_WEIGHT)
			+ ERR_W'(spread_s1) * ERR_W'(ERR_SPREAD_WEIGHT);
	end

	always_ff @(posedge clk) begin
		err_s2 <= err;
		lo_s2  <= lo_s1;
		hi_s2  <= hi_s1;
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= cmd.run;
			valid_s2 <= valid_s1;
		end
	end

	// running minimum, first strict minimum wins
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_err_q <= ERR_START;
			best_lo_q  <= '0;
			best_hi_q  <= '0;
		end else if (cmd.start) begin
			best_err_q <= ERR_START;
			best_lo_q  <= '0;
			best_hi_q  <= '0;
		end else if (valid_s2 && (err_s2 < best_err_q)) begin
			best_err_q <= err_s2;
			best_lo_q  <= lo_s2;
			best_hi_q  <= hi_s2;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_hi_q <= best_hi_q;
			out_lo_q <= best_lo_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign high_endpoint = out_hi_q;
	assign low_endpoint  = out_lo_q;

	// status
	assign sts.last_pair = (hi_q == code_max) && (lo_q == code_max);
	assign sts.pipe_busy = valid_s1 || valid_s2;
	assign sts.out_free  = !out_valid_q || out_ready;

	`DXTSC_ASSERT_IMP(a_best_bounded, clk, arst_n, 1'b1, best_err_q <= ERR_START)
	`DXTSC_ASSERT_IMP(a_load_drained, clk, arst_n, cmd.load_out, !valid_s1 && !valid_s2)
	`DXTSC_ASSERT_NXT(a_run_feeds, clk, arst_n, cmd.run, valid_s1)

endmodule

>>> hdl/dxt_single_color_endpoint_search.sv
// operation: from the accepting edge, every endpoint pair is searched (32*32 pairs for 5-bit codes or
// 64*64 for 6-bit codes); the result also waits for any result still held in the output register
// scan: one endpoint pair per cycle from the pair counter, then two error pipeline stages and
// the result load; a new target is accepted only once the controller is idle again
// reset: arst_n clears control state and sets endpoint_bits to 5; no result is pending
module dxt_single_color_endpoint_search
	import dxtsc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write_en,
	input  logic [CFG_W-1:0]    cfg_write_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [TARGET_W-1:0] target_value,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [CODE_W-1:0]   high_endpoint,
	output logic [CODE_W-1:0]   low_endpoint
);

	dxtsc_cmd_t cmd;
	dxtsc_sts_t sts;

	// sequencer
	dxtsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// search datapath
	dxtsc_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.target_value   (target_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.high_endpoint  (high_endpoint),
		.low_endpoint   (low_endpoint)
	);

endmodule
